// ===== hdl/wra_pkg.sv =====
package wra_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int DIV_STEPS   = 64;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic signed [63:0] MAX_S64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN_S64 = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] FIX_LIM   = MAX_S64 >>> FRAC_BITS;
   localparam logic signed [63:0] FIX_LIM_N = -FIX_LIM - 64'sd1;
   localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

   localparam logic [1:0] KIND_INT  = 2'd0;
   localparam logic [1:0] KIND_FIX  = 2'd1;
   localparam logic [1:0] KIND_BOOL = 2'd2;
   localparam logic [1:0] KIND_ALT  = 2'd3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   localparam logic [1:0] CSR_WINDOW_INTERVAL  = 2'd0;
   localparam logic [1:0] CSR_AGGREGATE_METHOD = 2'd1;

   typedef enum logic [2:0] {
      METH_NONE  = 3'd0,
      METH_MIN   = 3'd1,
      METH_MAX   = 3'd2,
      METH_AVG   = 3'd3,
      METH_LAST  = 3'd4,
      METH_COUNT = 3'd5,
      METH_SUM   = 3'd6,
      METH_SUM7  = 3'd7
   } method_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_AVG_DIV,
      ST_EMIT,
      ST_MOD_DIV,
      ST_REOPEN,
      ST_SEED,
      ST_ACC,
      ST_PASS
   } state_type;

   typedef struct packed {
      logic               opcode;
      logic [63:0]        sample_time;
      logic [1:0]         value_kind;
      logic signed [63:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [63:0]        out_timestamp;
      logic [1:0]         result_kind;
      logic signed [63:0] result_value;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear_win;
      logic open_win;
      logic open_from_rem;
      logic div_start;
      logic div_mod;
      logic seed;
      logic acc;
      logic emit_load;
      logic pass_load;
   } cmd_type;

   typedef struct packed {
      logic interval_zero;
      logic op_flush;
      logic win_open;
      logic has_samples;
      logic t_old;
      logic t_in_win;
      logic avg_div;
      logic div_busy;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic               sat;
      logic signed [63:0] val;
   } sat_res_type;

   function automatic sat_res_type sat_add(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      sat_res_type r;
      logic signed [63:0] s;
      s = a + b;
      r.sat = 1'b0;
      r.val = s;
      if (a[63] == b[63] && s[63] != a[63]) begin
         r.sat = 1'b1;
         r.val = b[63] ? MIN_S64 : MAX_S64;
      end
      return r;
   endfunction

   function automatic sat_res_type to_fix(input logic signed [63:0] v);
      sat_res_type r;
      r.sat = 1'b0;
      r.val = v <<< FRAC_BITS;
      if (v > FIX_LIM) begin
         r.sat = 1'b1;
         r.val = MAX_S64;
      end else if (v < FIX_LIM_N) begin
         r.sat = 1'b1;
         r.val = MIN_S64;
      end
      return r;
   endfunction

endpackage

// ===== hdl/windowed_rollup_aggregator_top.sv =====
// Tumbling-window rollup of a time-ordered sample stream. Each accepted beat
// is worked one at a time: a sample inside the open window goes through
// decode, fixed-point seed and accumulate before intake resumes; after
// decode, a pass-through sample waits for the result register to be free. A
// sample that closes a window runs the shared 64-step restoring divider once
// for the window skip, and once more before it when the method is a rounded
// average, and waits for the result register between the two runs. A flush
// with an open window emits its result, after the divider run for an average,
// once the result register is free. The result register lets intake resume
// while a closed window's result waits to be taken. Configuration writes are
// always ready.
module windowed_rollup_aggregator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wra_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wra_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import wra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   wra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wra_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef SYNTH
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> sts.div_busy) else $error("divider did not start");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.pass_load) |-> sts.out_free)
      else $error("result overwritten");
   a_acc_open: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> sts.win_open) else $error("accumulate without window");
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !sts.div_busy) else $error("divider busy while idle");
`endif

endmodule

// ===== hdl/wra_div.sv =====
module wra_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        busy,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);
   import wra_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]          quo_ff, quo_in;
   logic [63:0]          rem_ff, rem_in;
   logic [63:0]          dsr_ff, dsr_in;
   logic [64:0]          rem_sh, diff;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[63]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      diff    = rem_sh - {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? diff[63:0] : rem_sh[63:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/wra_ctrl.sv =====
module wra_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wra_pkg::sts_type sts,
   output wra_pkg::cmd_type cmd
);
   import wra_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.interval_zero) begin
               if (sts.op_flush) begin
                  cmd.clear_win = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_PASS;
               end
            end else if (sts.op_flush) begin
               if (sts.win_open && sts.has_samples) begin
                  if (sts.avg_div) begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_AVG_DIV;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  cmd.clear_win = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (!sts.win_open) begin
               cmd.clear_win = 1'b1;
               cmd.open_win  = 1'b1;
               state_in      = ST_SEED;
            end else if (sts.t_old) begin
               state_in = ST_IDLE;
            end else if (sts.t_in_win) begin
               state_in = ST_SEED;
            end else if (sts.has_samples) begin
               if (sts.avg_div) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_AVG_DIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_mod   = 1'b1;
               state_in      = ST_MOD_DIV;
            end
         end
         ST_AVG_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.op_flush) begin
                  cmd.clear_win = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_mod   = 1'b1;
                  state_in      = ST_MOD_DIV;
               end
            end
         end
         ST_MOD_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_REOPEN;
            end
         end
         ST_REOPEN: begin
            cmd.clear_win     = 1'b1;
            cmd.open_win      = 1'b1;
            cmd.open_from_rem = 1'b1;
            state_in          = ST_SEED;
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PASS: begin
            if (sts.out_free) begin
               cmd.pass_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/wra_dp.sv =====
module wra_dp (
   input  logic             clock,
   input  logic             reset,
   input  wra_pkg::req_type req_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output wra_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   input  wra_pkg::cmd_type cmd,
   output wra_pkg::sts_type sts
);
   import wra_pkg::*;

   logic [63:0]        interval_ff, interval_in;
   logic [2:0]         method_ff, method_in;
   req_type            item_ff, item_in;

   logic [63:0]        wstart_ff, wstart_in;
   logic               wopen_ff, wopen_in;
   logic signed [63:0] isum_ff, isum_in, imin_ff, imin_in, imax_ff, imax_in;
   logic signed [63:0] fsum_ff, fsum_in, fmin_ff, fmin_in, fmax_ff, fmax_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic               allint_ff, allint_in;
   logic [1:0]         lkind_ff, lkind_in;
   logic signed [63:0] lval_ff, lval_in;
   logic               sat_ff, sat_in;

   logic               rvalid_ff, rvalid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [63:0]        t_rel, cnt64, s_mag, div_a, div_b, quo, rem;
   logic signed [63:0] s_sel, rd, fsh, x_mm, n_val;
   logic [64:0]        twice_r;
   logic               half_up, div_busy, lb, out_free;
   method_type         meth;
   rsp_type            emit_r;
   sat_res_type        ra, rb, rc;

   wra_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .quotient  (quo),
      .remainder (rem)
   );

   always_comb begin
      meth     = method_type'(method_ff);
      lb       = (lkind_ff == KIND_BOOL);
      cnt64    = 64'(cnt_ff);
      t_rel    = item_ff.sample_time - wstart_ff;
      out_free = !rvalid_ff || !rsp_stall;
      s_sel    = allint_ff ? isum_ff : fsum_ff;
      s_mag    = s_sel[63] ? 64'(-s_sel) : 64'(s_sel);
      div_a    = cmd.div_mod ? t_rel : s_mag;
      div_b    = cmd.div_mod ? interval_ff : cnt64;

      sts.interval_zero = (interval_ff == 64'd0);
      sts.op_flush      = (item_ff.opcode == OP_FLUSH);
      sts.win_open      = wopen_ff;
      sts.has_samples   = (cnt_ff != '0);
      sts.t_old         = (item_ff.sample_time < wstart_ff);
      sts.t_in_win      = (t_rel < interval_ff);
      sts.avg_div       = (meth == METH_AVG) && (allint_ff || !lb);
      sts.div_busy      = div_busy;
      sts.out_free      = out_free;
   end

   always_comb begin
      twice_r = {rem, 1'b0};
      half_up = twice_r >= {1'b0, cnt64};
      if (!s_sel[63]) begin
         rd = $signed(quo + 64'(half_up));
      end else if (quo == 64'd0 && !half_up) begin
         rd = '0;
      end else begin
         rd = -$signed(quo - 64'(!half_up));
      end
      fsh  = (fsum_ff >>> FRAC_BITS)
           + ((fsum_ff[63] && ((fsum_ff & FRAC_MASK) != 64'd0)) ? 64'sd1 : 64'sd0);
      x_mm = (meth == METH_MIN) ? fmin_ff : fmax_ff;

      emit_r.out_timestamp = wstart_ff;
      emit_r.saturated     = sat_ff;
      emit_r.result_kind   = KIND_FIX;
      emit_r.result_value  = '0;
      if (meth == METH_LAST) begin
         emit_r.result_kind  = lkind_ff;
         emit_r.result_value = lval_ff;
      end else if (meth == METH_COUNT) begin
         emit_r.result_kind  = KIND_INT;
         emit_r.result_value = $signed(cnt64);
      end else if (allint_ff) begin
         emit_r.result_kind = KIND_INT;
         case (meth)
            METH_MIN: emit_r.result_value = imin_ff;
            METH_MAX: emit_r.result_value = imax_ff;
            METH_AVG: emit_r.result_value = rd;
            default:  emit_r.result_value = isum_ff;
         endcase
      end else if (meth == METH_MIN || meth == METH_MAX) begin
         if (lb) begin
            emit_r.result_kind  = KIND_BOOL;
            emit_r.result_value = 64'(!x_mm[63] && ({x_mm[62:0], 1'b0} > (64'd1 << FRAC_BITS)));
         end else begin
            emit_r.result_value = x_mm;
         end
      end else if (meth == METH_AVG) begin
         if (lb) begin
            emit_r.result_kind  = KIND_BOOL;
            emit_r.result_value = 64'(!fsum_ff[63]
                                  && ({fsum_ff[62:0], 1'b0} > (cnt64 << FRAC_BITS)));
         end else begin
            emit_r.result_value = rd;
         end
      end else begin
         if (lb) begin
            emit_r.result_kind  = KIND_INT;
            emit_r.result_value = fsh;
         end else begin
            emit_r.result_value = fsum_ff;
         end
      end
   end

   always_comb begin
      interval_in = interval_ff;
      method_in   = method_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_INTERVAL:  interval_in = csr_wdata;
            CSR_AGGREGATE_METHOD: method_in   = csr_wdata[2:0];
            default: ;
         endcase
      end

      item_in = item_ff;
      if (cmd.load) begin
         item_in = req_data;
         if (req_data.value_kind == KIND_ALT) begin
            item_in.value_kind = KIND_INT;
         end
         if (req_data.value_kind == KIND_BOOL) begin
            item_in.sample_value = 64'(req_data.sample_value != 64'sd0);
         end
      end

      wstart_in = wstart_ff;
      wopen_in  = wopen_ff;
      isum_in   = isum_ff;
      imin_in   = imin_ff;
      imax_in   = imax_ff;
      fsum_in   = fsum_ff;
      fmin_in   = fmin_ff;
      fmax_in   = fmax_ff;
      cnt_in    = cnt_ff;
      allint_in = allint_ff;
      lkind_in  = lkind_ff;
      lval_in   = lval_ff;
      sat_in    = sat_ff;
      ra        = '0;
      rb        = '0;
      rc        = '0;
      n_val     = item_ff.sample_value;

      if (cmd.clear_win) begin
         wstart_in = '0;
         wopen_in  = 1'b0;
         isum_in   = '0;
         imin_in   = MAX_S64;
         imax_in   = MIN_S64;
         fsum_in   = '0;
         fmin_in   = MAX_S64;
         fmax_in   = MIN_S64;
         cnt_in    = '0;
         allint_in = 1'b1;
         lkind_in  = KIND_FIX;
         lval_in   = '0;
         sat_in    = 1'b0;
      end
      if (cmd.open_win) begin
         wopen_in  = 1'b1;
         wstart_in = cmd.open_from_rem ? item_ff.sample_time - rem : item_ff.sample_time;
      end

      if (cmd.seed && allint_ff && cnt_ff != '0 && item_ff.value_kind != KIND_INT) begin
         ra      = to_fix(isum_ff);
         rb      = to_fix(imin_ff);
         rc      = to_fix(imax_ff);
         fsum_in = ra.val;
         fmin_in = rb.val;
         fmax_in = rc.val;
         sat_in  = sat_ff | ra.sat | rb.sat | rc.sat;
      end

      if (cmd.acc) begin
         lkind_in = item_ff.value_kind;
         lval_in  = item_ff.sample_value;
         if (item_ff.value_kind == KIND_INT) begin
            ra      = sat_add(isum_ff, item_ff.sample_value);
            isum_in = ra.val;
            if (item_ff.sample_value < imin_ff) imin_in = item_ff.sample_value;
            if (item_ff.sample_value > imax_ff) imax_in = item_ff.sample_value;
            if (!allint_ff) begin
               rb = to_fix(item_ff.sample_value);
               rc = sat_add(fsum_ff, rb.val);
               fsum_in = rc.val;
               if (rb.val < fmin_ff) fmin_in = rb.val;
               if (rb.val > fmax_ff) fmax_in = rb.val;
            end
         end else begin
            if (item_ff.value_kind == KIND_BOOL) begin
               n_val = item_ff.sample_value <<< FRAC_BITS;
            end
            allint_in = 1'b0;
            rc        = sat_add(fsum_ff, n_val);
            fsum_in   = rc.val;
            if (n_val < fmin_ff) fmin_in = n_val;
            if (n_val > fmax_ff) fmax_in = n_val;
         end
         if (cnt_ff != COUNT_MAX) begin
            cnt_in = cnt_ff + COUNT_WIDTH'(1);
         end
         sat_in = sat_ff | ra.sat | rb.sat | rc.sat | (cnt_ff == COUNT_MAX);
      end

      rvalid_in = rvalid_ff && rsp_stall;
      rsp_in    = rsp_ff;
      if (cmd.emit_load) begin
         rvalid_in = 1'b1;
         rsp_in    = emit_r;
      end else if (cmd.pass_load) begin
         rvalid_in            = 1'b1;
         rsp_in.out_timestamp = item_ff.sample_time;
         rsp_in.result_kind   = item_ff.value_kind;
         rsp_in.result_value  = item_ff.sample_value;
         rsp_in.saturated     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         method_ff   <= '0;
         wstart_ff   <= '0;
         wopen_ff    <= 1'b0;
         isum_ff     <= '0;
         imin_ff     <= MAX_S64;
         imax_ff     <= MIN_S64;
         fsum_ff     <= '0;
         fmin_ff     <= MAX_S64;
         fmax_ff     <= MIN_S64;
         cnt_ff      <= '0;
         allint_ff   <= 1'b1;
         lkind_ff    <= KIND_FIX;
         lval_ff     <= '0;
         sat_ff      <= 1'b0;
         rvalid_ff   <= 1'b0;
      end else begin
         interval_ff <= interval_in;
         method_ff   <= method_in;
         wstart_ff   <= wstart_in;
         wopen_ff    <= wopen_in;
         isum_ff     <= isum_in;
         imin_ff     <= imin_in;
         imax_ff     <= imax_in;
         fsum_ff     <= fsum_in;
         fmin_ff     <= fmin_in;
         fmax_ff     <= fmax_in;
         cnt_ff      <= cnt_in;
         allint_ff   <= allint_in;
         lkind_ff    <= lkind_in;
         lval_ff     <= lval_in;
         sat_ff      <= sat_in;
         rvalid_ff   <= rvalid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/windowed_rollup_aggregator_top_tb.sv =====
`timescale 1ns / 1ps

module windowed_rollup_aggregator_top_tb;
   import wra_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE      = 200;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   windowed_rollup_aggregator_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fails = 0;
   int quiet = 0;
   logic [63:0] cur_time = 0;

   rsp_type rollup_q[$];

   // window state mirror
   logic [63:0]        span = 0;
   method_type         meth = METH_NONE;
   logic [63:0]        win_base;
   logic               win_live;
   logic signed [63:0] isum, imin, imax, fsum, fmin, fmax;
   logic [63:0]        n_seen;
   logic               only_int;
   logic [1:0]         tail_kind;
   logic signed [63:0] tail_val;
   logic               clamp_hit;

   function automatic void clear_win();
      win_base = 0; win_live = 0;
      isum = 0; imin = MAX_S64; imax = MIN_S64;
      fsum = 0; fmin = MAX_S64; fmax = MIN_S64;
      n_seen = 0; only_int = 1; tail_kind = KIND_FIX; tail_val = 0; clamp_hit = 0;
   endfunction

   function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      if (b > 0 && a > MAX_S64 - b) begin
         clamp_hit = 1; return MAX_S64;
      end
      if (b < 0 && a < MIN_S64 - b) begin
         clamp_hit = 1; return MIN_S64;
      end
      return a + b;
   endfunction

   function automatic logic signed [63:0] fix_of(input logic signed [63:0] v);
      if (v > FIX_LIM) begin
         clamp_hit = 1; return MAX_S64;
      end
      if (v < FIX_LIM_N) begin
         clamp_hit = 1; return MIN_S64;
      end
      return v * (64'sd1 <<< FRAC_BITS);
   endfunction

   function automatic logic signed [63:0] round_avg(input logic signed [63:0] s,
                                                    input logic [63:0] c);
      logic signed [63:0] cc, q, r, m, f;
      logic inexact;
      cc = c;
      q = s / cc;
      r = s % cc;
      m = 2 * r + cc;
      f = q + ((m < 0) ? -64'sd1 : ((m >= 2 * cc) ? 64'sd1 : 64'sd0));
      inexact = !(m == 0 || m == 2 * cc);
      if (f < 0 && inexact) f = f + 1;
      return f;
   endfunction

   function automatic logic over_half(input logic signed [63:0] v, input logic [63:0] c);
      logic [63:0] uv;
      uv = v;
      if (v <= 0) return 0;
      return (uv << 1) > (c << FRAC_BITS);
   endfunction

   function automatic void add_sample(input logic [1:0] k, input logic signed [63:0] v);
      logic signed [63:0] f;
      tail_kind = k;
      tail_val = v;
      if (k == KIND_INT) begin
         isum = add_clamp(isum, v);
         if (v < imin) imin = v;
         if (v > imax) imax = v;
         if (!only_int) begin
            f = fix_of(v);
            fsum = add_clamp(fsum, f);
            if (f < fmin) fmin = f;
            if (f > fmax) fmax = f;
         end
      end else begin
         f = (k == KIND_FIX) ? v : fix_of(v);
         if (only_int && n_seen > 0) begin
            fsum = fix_of(isum);
            fmin = fix_of(imin);
            fmax = fix_of(imax);
         end
         only_int = 0;
         fsum = add_clamp(fsum, f);
         if (f < fmin) fmin = f;
         if (f > fmax) fmax = f;
      end
      if (n_seen < {32'd0, COUNT_MAX}) n_seen++;
      else clamp_hit = 1;
   endfunction

   function automatic rsp_type close_win();
      rsp_type o;
      logic lb;
      logic signed [63:0] x;
      lb = (tail_kind == KIND_BOOL);
      o.out_timestamp = win_base;
      o.saturated = clamp_hit;
      o.result_kind = KIND_FIX;
      if (meth == METH_LAST) begin
         o.result_kind = tail_kind; o.result_value = tail_val;
      end else if (meth == METH_COUNT) begin
         o.result_kind = KIND_INT; o.result_value = n_seen;
      end else if (only_int) begin
         o.result_kind = KIND_INT;
         case (meth)
            METH_MIN: o.result_value = imin;
            METH_MAX: o.result_value = imax;
            METH_AVG: o.result_value = round_avg(isum, n_seen);
            default:  o.result_value = isum;
         endcase
      end else if (meth == METH_MIN || meth == METH_MAX) begin
         x = (meth == METH_MIN) ? fmin : fmax;
         if (lb) begin
            o.result_kind = KIND_BOOL; o.result_value = 64'(over_half(x, 64'd1));
         end else o.result_value = x;
      end else if (meth == METH_AVG) begin
         if (lb) begin
            o.result_kind = KIND_BOOL; o.result_value = 64'(over_half(fsum, n_seen));
         end else o.result_value = round_avg(fsum, n_seen);
      end else begin
         if (lb) begin
            o.result_kind = KIND_INT; o.result_value = fsum / (64'sd1 <<< FRAC_BITS);
         end else o.result_value = fsum;
      end
      return o;
   endfunction

   function automatic void rollup_step(input req_type it);
      logic [1:0] k;
      logic signed [63:0] v;
      logic [63:0] t, nxt;
      rsp_type o;
      k = (it.value_kind == KIND_ALT) ? KIND_INT : it.value_kind;
      v = it.sample_value;
      t = it.sample_time;
      if (k == KIND_BOOL) v = (v != 0) ? 64'sd1 : 64'sd0;
      if (span == 0) begin
         if (it.opcode == OP_FLUSH) clear_win();
         else begin
            o.out_timestamp = t; o.result_kind = k; o.result_value = v; o.saturated = 0;
            rollup_q.push_back(o);
         end
      end else if (it.opcode == OP_FLUSH) begin
         if (win_live && n_seen > 0) rollup_q.push_back(close_win());
         clear_win();
      end else if (!win_live) begin
         clear_win();
         win_live = 1; win_base = t;
         add_sample(k, v);
      end else if (t < win_base) begin
      end else if (t - win_base < span) begin
         add_sample(k, v);
      end else begin
         nxt = win_base + ((t - win_base) / span) * span;
         if (n_seen > 0) rollup_q.push_back(close_win());
         clear_win();
         win_live = 1; win_base = nxt;
         add_sample(k, v);
      end
   endfunction

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rollup_q.size() == 0) begin
            $error("unexpected result beat ts=%0h", rsp_data.out_timestamp);
            fails++;
         end else begin
            e = rollup_q.pop_front();
            if (rsp_data.out_timestamp !== e.out_timestamp) begin
               $error("out_timestamp exp %0h got %0h", e.out_timestamp, rsp_data.out_timestamp);
               fails++;
            end
            if (rsp_data.result_kind !== e.result_kind) begin
               $error("result_kind exp %0d got %0d", e.result_kind, rsp_data.result_kind);
               fails++;
            end
            if (rsp_data.result_value !== e.result_value) begin
               $error("result_value exp %0d got %0d", e.result_value, rsp_data.result_value);
               fails++;
            end
            if (rsp_data.saturated !== e.saturated) begin
               $error("saturated exp %0b got %0b", e.saturated, rsp_data.saturated);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet <= 0;
      else if (quiet >= QUIET_LIMIT) begin
         $display("windowed_rollup_aggregator_top regression: fail");
         $finish;
      end else
         quiet <= quiet + 1;
   end

   task automatic send_beat(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!(req_valid && !req_stall));
      rollup_step(it);
      @(negedge clock);
   endtask

   task automatic sample(input logic [63:0] t, input logic [1:0] k,
                         input logic signed [63:0] v);
      req_type it;
      it.opcode = OP_SAMPLE; it.sample_time = t; it.value_kind = k; it.sample_value = v;
      send_beat(it);
   endtask

   task automatic flush();
      req_type it;
      it = '0;
      it.opcode = OP_FLUSH;
      it.sample_time = {$urandom, $urandom};
      it.value_kind = 2'($urandom_range(3));
      it.sample_value = {$urandom, $urandom};
      send_beat(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rollup_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] d);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WINDOW_INTERVAL) span = d;
      else meth = method_type'(d[2:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_pass_through();
      csr_write(CSR_WINDOW_INTERVAL, 64'd0);
      sample(64'd0, KIND_INT, MAX_S64);
      sample(64'hFFFF_FFFF_FFFF_FFFF, KIND_FIX, MIN_S64);
      sample(64'd5, KIND_BOOL, -64'sd7);
      sample(64'd6, KIND_BOOL, 64'sd0);
      sample(64'd7, KIND_ALT, -64'sd1);
      flush();
   endtask

   task automatic test_methods();
      csr_write(CSR_WINDOW_INTERVAL, 64'd10);
      flush();
      for (int m = 0; m < 8; m++) begin
         csr_write(CSR_AGGREGATE_METHOD, 64'(m));
         sample(64'd100, KIND_INT, 64'sd3);
         sample(64'd104, KIND_INT, -64'sd8);
         sample(64'd95, KIND_INT, 64'sd1000);
         sample(64'd125, KIND_INT, 64'sd5);
         sample(64'd126, KIND_FIX, 64'sh18000);
         sample(64'd127, KIND_BOOL, 64'sd9);
         sample(64'd150, KIND_INT, MAX_S64);
         sample(64'd151, KIND_INT, 64'sd2);
         sample(64'd152, KIND_FIX, 64'sd1);
         flush();
      end
   endtask

   task automatic rand_item();
      logic [63:0] lim;
      logic signed [63:0] v;
      if ($urandom_range(99) < 5) begin
         flush();
         return;
      end
      lim = (span == 0 || span > 1000) ? 64'd1000 : span;
      case ($urandom_range(9))
         0: ;
         1: cur_time = cur_time + ({$urandom, $urandom} >> $urandom_range(63));
         2: cur_time = cur_time - 64'($urandom_range(50));
         default: cur_time = cur_time + 64'($urandom_range(0, 32'(2 * lim)));
      endcase
      case ($urandom_range(6))
         0: v = MAX_S64;
         1: v = MIN_S64;
         2: v = {$urandom, $urandom};
         3: v = $signed(64'($urandom_range(2000))) - 64'sd1000;
         default: v = ($signed(64'($urandom_range(2000))) - 64'sd1000) * 64'sd4096;
      endcase
      sample(cur_time, 2'($urandom_range(3)), v);
   endtask

   task automatic test_random(input int snd, input int rcv, input int items);
      logic [63:0] s;
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      for (int c = 0; c < 8; c++) begin
         case (c % 5)
            0: s = 64'd1;
            1: s = 64'($urandom_range(2, 64));
            2: s = 64'($urandom_range(1, 1000));
            3: s = 64'hFFFF_FFFF_FFFF_FFFF;
            default: s = (c == 4) ? 64'd0 : 64'($urandom_range(1, 20));
         endcase
         csr_write(CSR_WINDOW_INTERVAL, s);
         csr_write(CSR_AGGREGATE_METHOD, 64'($urandom_range(7)));
         if (s == 64'hFFFF_FFFF_FFFF_FFFF) cur_time = {$urandom, $urandom};
         for (int i = 0; i < items / 8; i++) rand_item();
         flush();
      end
   endtask

   task automatic test_pause_until_empty();
      send_idle_pct = 10;
      recv_idle_pct = 60;
      csr_write(CSR_WINDOW_INTERVAL, 64'd4);
      csr_write(CSR_AGGREGATE_METHOD, 64'(METH_AVG));
      for (int i = 0; i < 20; i++) sample(cur_time + 64'(4 * i), KIND_INT, 64'(i));
      req_valid <= 1'b0;
      while (rollup_q.size() != 0) @(posedge clock);
      @(negedge clock);
      cur_time = cur_time + 200;
      sample(cur_time, KIND_FIX, 64'sh10000);
      flush();
   endtask

   initial begin
      clear_win();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_pass_through();
      test_methods();
      test_random(32, 47, 400);
      test_random(47, 32, 400);
      test_random(0, 0, 400);
      test_pause_until_empty();
      drain();
      if (fails == 0)
         $display("windowed_rollup_aggregator_top regression: pass");
      else
         $display("windowed_rollup_aggregator_top regression: fail");
      $finish;
   end

endmodule
